// ===== rtl/core/drum_trigger_peak_detector_macros.svh =====
// Assertion macros for the drum trigger peak detector checker.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef DRUM_TRIGGER_PEAK_DETECTOR_MACROS_SVH
`define DRUM_TRIGGER_PEAK_DETECTOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DTPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define DTPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/dtpd_pkg.sv =====
// Shared constants, types and state encoding for the drum trigger peak detector.
// No dependencies.
package dtpd_pkg;

  localparam int WINDOW_LEN  = 8;
  localparam int RAW_BITS    = 10;
  localparam int LEVEL_BITS  = 7;
  localparam int FS_BITS     = 10;
  localparam int TIME_BITS   = 32;
  localparam int GAP_BITS    = 20;
  localparam int MARGIN_BITS = 7;
  localparam int TREND_BITS  = 8;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_IDX_W   = 2;

  localparam int WIN_AW    = $clog2(WINDOW_LEN);
  localparam int SCAN_CW   = $clog2(WINDOW_LEN + 1);
  localparam int LEVEL_MAX = (1 << LEVEL_BITS) - 1;

  // divider working width: numerator raw*LEVEL_MAX and divisor shifted by LEVEL_BITS
  localparam int DIV_W  = ((RAW_BITS > FS_BITS) ? RAW_BITS : FS_BITS) + LEVEL_BITS;
  localparam int STEP_W = $clog2(LEVEL_BITS);

  // trend divide by WINDOW_LEN-1 as multiply by rounded-up reciprocal, exact for 7-bit input
  localparam int TR_DIV    = WINDOW_LEN - 1;
  localparam int TR_SHIFT  = 14;
  localparam int TR_MULT   = ((1 << TR_SHIFT) + TR_DIV - 1) / TR_DIV;
  localparam int TR_MULT_W = TR_SHIFT + 1;
  localparam int TR_PROD_W = LEVEL_BITS + TR_MULT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUIET_GAP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN     = 2'd3;

  localparam logic [FS_BITS-1:0]     FS_RESET      = 10'd200;
  localparam logic [GAP_BITS-1:0]    GAP_RESET     = 20'd80000;
  localparam logic [GAP_BITS-1:0]    LOCKOUT_RESET = 20'd80000;
  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET  = 7'd5;

  typedef logic [LEVEL_BITS-1:0] level_t;
  typedef logic [WIN_AW-1:0]     slot_t;

  typedef struct packed {
    logic   wr_en;
    slot_t  wr_addr;
    level_t wr_data;
    slot_t  rd_addr;
  } win_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_OLD,
    ST_CAP_OLD,
    ST_WAIT_DIV,
    ST_WRITE,
    ST_SCAN,
    ST_UPDATE,
    ST_QUIET,
    ST_OUT
  } dtpd_state_t;

endpackage

// ===== rtl/core/dtpd_scale.sv =====
// Sample scaler: level = min(raw*LEVEL_MAX/full_scale, LEVEL_MAX), one quotient bit per cycle.
// Depends on dtpd_pkg.
module dtpd_scale (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dtpd_pkg::RAW_BITS-1:0] raw_sample,
  input  logic [dtpd_pkg::FS_BITS-1:0]  full_scale,
  output dtpd_pkg::level_t             level,
  output logic                         level_valid
);
  import dtpd_pkg::*;

  logic [DIV_W-1:0]  num_c;
  logic              sat_c;
  logic              ge_c;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  dsr_r;
  logic [STEP_W-1:0] step_r;
  level_t            q_r;
  logic              busy_r;
  logic              valid_r;

  always_comb begin
    num_c = (DIV_W'(raw_sample) << LEVEL_BITS) - DIV_W'(raw_sample);
    // quotient of LEVEL_MAX+1 or more clamps, as does a zero divisor
    sat_c = (full_scale == '0) || (num_c >= (DIV_W'(full_scale) << LEVEL_BITS));
    ge_c  = rem_r >= dsr_r;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num_c;
      dsr_r  <= DIV_W'(full_scale) << (LEVEL_BITS - 1);
      step_r <= STEP_W'(LEVEL_BITS - 1);
      q_r    <= sat_c ? level_t'(LEVEL_MAX) : '0;
    end else if (busy_r) begin
      if (ge_c) begin
        rem_r <= rem_r - dsr_r;
      end
      dsr_r  <= dsr_r >> 1;
      q_r    <= {q_r[LEVEL_BITS-2:0], ge_c};
      step_r <= step_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else if (start) begin
      busy_r  <= !sat_c;
      valid_r <= sat_c;
    end else if (busy_r && step_r == '0) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b1;
    end
  end

  assign level       = q_r;
  assign level_valid = valid_r;

endmodule

// ===== rtl/core/dtpd_window.sv =====
// Sample window store: one write and one registered read per cycle.
// Entries never written read as zero via per-entry valid bits. Depends on dtpd_pkg.
module dtpd_window (
  input  logic                clk,
  input  logic                rst_n,
  input  dtpd_pkg::win_req_t  req,
  output dtpd_pkg::level_t    rd_data
);
  import dtpd_pkg::*;

  level_t                mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] vld_r;
  level_t                rd_data_r;
  logic                  rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data_r <= mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[req.rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// ===== rtl/core/drum_trigger_peak_detector.sv =====
// Drum trigger peak detector top level: sequencer, peak and stroke logic, output register.
// Depends on dtpd_pkg, dtpd_scale, dtpd_window.
//
//   channel | direction | handshake            | payload
//   in      | request   | in_valid / in_stall  | raw_sample, timestamp_us
//   out     | result    | out_valid / out_stall| level .. window_silent
//   cfg     | write     | cfg_we               | cfg_index, cfg_wdata
//
// One request at a time: after an accept the sequencer reads the evicted and the
// oldest entry, waits for the 7-step scaler (skipped for a saturated level or a
// zero full scale), writes the level, rescans the window one entry per cycle when
// the evicted entry held the maximum, then updates trend, peak and quiet state.
// Reset is synchronous; the window reads as all zeros right after it.
// A result waiting on out_stall holds the sequencer in its last state only; a new
// request is taken as soon as the previous result is in the output register.
module drum_trigger_peak_detector (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [dtpd_pkg::RAW_BITS-1:0]    in_raw_sample,
  input  logic [dtpd_pkg::TIME_BITS-1:0]   in_timestamp_us,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [dtpd_pkg::LEVEL_BITS-1:0]  out_level,
  output logic [dtpd_pkg::LEVEL_BITS-1:0]  out_window_peak,
  output logic signed [dtpd_pkg::TREND_BITS-1:0] out_trend,
  output logic                             out_peak_seen,
  output logic                             out_stroke_hit,
  output logic [dtpd_pkg::LEVEL_BITS-1:0]  out_peak_level,
  output logic [dtpd_pkg::LEVEL_BITS-1:0]  out_stroke_level,
  output logic                             out_window_silent,
  input  logic                             cfg_we,
  input  logic [dtpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dtpd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import dtpd_pkg::*;

  dtpd_state_t state_r, state_nxt;

  // configuration
  logic [FS_BITS-1:0]     fs_r;
  logic [GAP_BITS-1:0]    gap_r;
  logic [GAP_BITS-1:0]    lockout_r;
  logic [MARGIN_BITS-1:0] margin_r;

  // state kept across requests
  slot_t                  slot_r, slot_nxt;
  level_t                 peak_r, peak_nxt;
  logic [TREND_BITS-1:0]  trend_r, trend_nxt;
  logic [TIME_BITS-1:0]   last_active_r, last_active_nxt;
  level_t                 pk_level_r, pk_level_nxt;
  logic [TIME_BITS-1:0]   pk_time_r, pk_time_nxt;
  level_t                 stroke_latch_r, stroke_latch_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // per-request working registers
  logic [TIME_BITS-1:0]   ts_r, ts_nxt;
  level_t                 evicted_r, evicted_nxt;
  level_t                 oldest_r, oldest_nxt;
  logic [TR_PROD_W-1:0]   prod_r, prod_nxt;
  logic                   neg_r, neg_nxt;
  level_t                 scan_acc_r, scan_acc_nxt;
  logic [SCAN_CW-1:0]     scan_cnt_r, scan_cnt_nxt;
  logic                   peak_flag_r, peak_flag_nxt;
  logic                   stroke_flag_r, stroke_flag_nxt;

  // output register
  level_t                 o_level_r, o_level_nxt;
  level_t                 o_wpeak_r, o_wpeak_nxt;
  logic [TREND_BITS-1:0]  o_trend_r, o_trend_nxt;
  logic                   o_peak_r, o_peak_nxt;
  logic                   o_stroke_r, o_stroke_nxt;
  level_t                 o_pk_level_r, o_pk_level_nxt;
  level_t                 o_st_level_r, o_st_level_nxt;
  logic                   o_silent_r, o_silent_nxt;

  win_req_t win_req;
  level_t   win_rd;
  level_t   div_level;
  logic     div_valid;
  logic     accept;
  logic     out_free;

  slot_t                 slot_next_c;
  slot_t                 oldest_slot_c;
  level_t                mag_c;
  level_t                fold_c;
  level_t                tq_c;
  logic [TREND_BITS-1:0] tmag_c;
  logic [TREND_BITS-1:0] trend_new_c;
  logic [TIME_BITS-1:0]  since_peak_c;
  logic [TIME_BITS-1:0]  since_active_c;
  logic [LEVEL_BITS:0]   bar_c;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  dtpd_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (accept),
    .raw_sample  (in_raw_sample),
    .full_scale  (fs_r),
    .level       (div_level),
    .level_valid (div_valid)
  );

  dtpd_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (win_req),
    .rd_data (win_rd)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_RD_OLD;
      ST_RD_OLD:   state_nxt = ST_CAP_OLD;
      ST_CAP_OLD:  state_nxt = ST_WAIT_DIV;
      ST_WAIT_DIV: if (div_valid) state_nxt = ST_WRITE;
      ST_WRITE:    state_nxt = (evicted_r == peak_r) ? ST_SCAN : ST_UPDATE;
      ST_SCAN:     if (scan_cnt_r == SCAN_CW'(WINDOW_LEN)) state_nxt = ST_UPDATE;
      ST_UPDATE:   state_nxt = ST_QUIET;
      ST_QUIET:    state_nxt = ST_OUT;
      ST_OUT:      if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    slot_next_c    = (slot_r == slot_t'(WINDOW_LEN - 1)) ? '0 : slot_r + 1'b1;
    oldest_slot_c  = slot_next_c;
    mag_c          = (div_level < oldest_r) ? oldest_r - div_level : div_level - oldest_r;
    fold_c         = (scan_cnt_r != '0 && win_rd > scan_acc_r) ? win_rd : scan_acc_r;
    tq_c           = prod_r[TR_SHIFT +: LEVEL_BITS];
    tmag_c         = {1'b0, tq_c};
    trend_new_c    = neg_r ? -tmag_c : tmag_c;
    since_peak_c   = ts_r - pk_time_r;
    since_active_c = ts_r - last_active_r;
    bar_c          = {1'b0, pk_level_r} + {1'b0, margin_r};

    win_req         = '0;
    slot_nxt        = slot_r;
    peak_nxt        = peak_r;
    trend_nxt       = trend_r;
    last_active_nxt = last_active_r;
    pk_level_nxt    = pk_level_r;
    pk_time_nxt     = pk_time_r;
    stroke_latch_nxt = stroke_latch_r;
    ts_nxt          = ts_r;
    evicted_nxt     = evicted_r;
    oldest_nxt      = oldest_r;
    prod_nxt        = prod_r;
    neg_nxt         = neg_r;
    scan_acc_nxt    = scan_acc_r;
    scan_cnt_nxt    = scan_cnt_r;
    peak_flag_nxt   = peak_flag_r;
    stroke_flag_nxt = stroke_flag_r;
    o_level_nxt     = o_level_r;
    o_wpeak_nxt     = o_wpeak_r;
    o_trend_nxt     = o_trend_r;
    o_peak_nxt      = o_peak_r;
    o_stroke_nxt    = o_stroke_r;
    o_pk_level_nxt  = o_pk_level_r;
    o_st_level_nxt  = o_st_level_r;
    o_silent_nxt    = o_silent_r;
    out_valid_nxt   = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        win_req.rd_addr = slot_next_c;
        if (accept) begin
          ts_nxt   = in_timestamp_us;
          slot_nxt = slot_next_c;
        end
      end
      ST_RD_OLD: begin
        evicted_nxt     = win_rd;
        win_req.rd_addr = oldest_slot_c;
      end
      ST_CAP_OLD: begin
        oldest_nxt = win_rd;
      end
      ST_WRITE: begin
        win_req.wr_en   = 1'b1;
        win_req.wr_addr = slot_r;
        win_req.wr_data = div_level;
        neg_nxt         = div_level < oldest_r;
        prod_nxt        = TR_PROD_W'(mag_c) * TR_PROD_W'(TR_MULT);
        scan_acc_nxt    = '0;
        scan_cnt_nxt    = '0;
        // old maximum still in the window unless it was just evicted
        if (evicted_r != peak_r && div_level > peak_r) begin
          peak_nxt = div_level;
        end
      end
      ST_SCAN: begin
        win_req.rd_addr = scan_cnt_r[WIN_AW-1:0];
        scan_acc_nxt    = fold_c;
        scan_cnt_nxt    = scan_cnt_r + 1'b1;
        if (scan_cnt_r == SCAN_CW'(WINDOW_LEN)) begin
          peak_nxt = fold_c;
        end
      end
      ST_UPDATE: begin
        trend_nxt       = trend_new_c;
        peak_flag_nxt   = 1'b0;
        stroke_flag_nxt = 1'b0;
        // rising trend turning flat or falling ends a peak
        if (!trend_r[TREND_BITS-1] && trend_r != '0 &&
            (trend_new_c[TREND_BITS-1] || trend_new_c == '0)) begin
          peak_flag_nxt = 1'b1;
          pk_time_nxt   = ts_r;
          pk_level_nxt  = peak_r;
          if (since_peak_c < TIME_BITS'(lockout_r)) begin
            stroke_flag_nxt = {1'b0, peak_r} > bar_c;
          end else begin
            stroke_flag_nxt = 1'b1;
          end
        end
      end
      ST_QUIET: begin
        if (div_level != '0) begin
          last_active_nxt = ts_r;
        end else if (since_active_c > TIME_BITS'(gap_r)) begin
          stroke_latch_nxt = peak_r;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          o_level_nxt    = div_level;
          o_wpeak_nxt    = peak_r;
          o_trend_nxt    = trend_r;
          o_peak_nxt     = peak_flag_r;
          o_stroke_nxt   = stroke_flag_r;
          o_pk_level_nxt = pk_level_r;
          o_st_level_nxt = stroke_latch_r;
          o_silent_nxt   = (peak_r == '0);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      slot_r         <= slot_t'(WINDOW_LEN - 1);
      peak_r         <= '0;
      trend_r        <= '0;
      last_active_r  <= '0;
      pk_level_r     <= '0;
      pk_time_r      <= '0;
      stroke_latch_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      slot_r         <= slot_nxt;
      peak_r         <= peak_nxt;
      trend_r        <= trend_nxt;
      last_active_r  <= last_active_nxt;
      pk_level_r     <= pk_level_nxt;
      pk_time_r      <= pk_time_nxt;
      stroke_latch_r <= stroke_latch_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ts_r          <= ts_nxt;
    evicted_r     <= evicted_nxt;
    oldest_r      <= oldest_nxt;
    prod_r        <= prod_nxt;
    neg_r         <= neg_nxt;
    scan_acc_r    <= scan_acc_nxt;
    scan_cnt_r    <= scan_cnt_nxt;
    peak_flag_r   <= peak_flag_nxt;
    stroke_flag_r <= stroke_flag_nxt;
    o_level_r     <= o_level_nxt;
    o_wpeak_r     <= o_wpeak_nxt;
    o_trend_r     <= o_trend_nxt;
    o_peak_r      <= o_peak_nxt;
    o_stroke_r    <= o_stroke_nxt;
    o_pk_level_r  <= o_pk_level_nxt;
    o_st_level_r  <= o_st_level_nxt;
    o_silent_r    <= o_silent_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r      <= FS_RESET;
      gap_r     <= GAP_RESET;
      lockout_r <= LOCKOUT_RESET;
      margin_r  <= MARGIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FULL_SCALE: fs_r      <= cfg_wdata[FS_BITS-1:0];
        CFG_QUIET_GAP:  gap_r     <= cfg_wdata[GAP_BITS-1:0];
        CFG_LOCKOUT:    lockout_r <= cfg_wdata[GAP_BITS-1:0];
        CFG_MARGIN:     margin_r  <= cfg_wdata[MARGIN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_level         = o_level_r;
  assign out_window_peak   = o_wpeak_r;
  assign out_trend         = o_trend_r;
  assign out_peak_seen     = o_peak_r;
  assign out_stroke_hit    = o_stroke_r;
  assign out_peak_level    = o_pk_level_r;
  assign out_stroke_level  = o_st_level_r;
  assign out_window_silent = o_silent_r;

endmodule

// ===== rtl/core/dtpd_checker.sv =====
// Port-level checks for the drum trigger peak detector, bound to the top level.
// Depends on drum_trigger_peak_detector_macros.svh.
`include "drum_trigger_peak_detector_macros.svh"

module dtpd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [6:0]        out_level,
  input logic [6:0]        out_window_peak,
  input logic signed [7:0] out_trend,
  input logic              out_peak_seen,
  input logic              out_stroke_hit,
  input logic [6:0]        out_peak_level,
  input logic              out_window_silent
);

  // silent window means the maximum is zero and the other way round
  `DTPD_ASSERT_NOW(a_silent_vs_peak, out_valid, out_window_silent == (out_window_peak == 7'd0), "window_silent disagrees with window_peak")

  `DTPD_ASSERT_NOW(a_stroke_needs_peak, out_valid && out_stroke_hit, out_peak_seen, "stroke without peak")

  // a fresh peak records the current window maximum
  `DTPD_ASSERT_NOW(a_peak_is_max, out_valid && out_peak_seen, out_peak_level == out_window_peak, "peak_level is not window max")

  // one request in flight: the input stalls right after an accept
  `DTPD_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second request taken while busy")

  `DTPD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_level) && $stable(out_trend), "stalled result changed")

endmodule

bind drum_trigger_peak_detector dtpd_checker u_dtpd_checker (.*);
